### rtl/tns_pkg.sv
// Shared types, constants and command/status structs of the note sequencer.
`timescale 1ns / 1ps

package tns_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int SPEED_UNIT  = 500;

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int POS_W   = 9;
    localparam int TICK_W  = 32;
    localparam int NOTE_W  = 16;
    localparam int CNT_W   = 9;
    localparam int SPEED_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W  = 2 * NOTE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 1'b1;

    localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(500);

    // Division by SPEED_UNIT is a multiplication by a rounded-up reciprocal.
    localparam int RECIP_SHIFT = PROD_W + $clog2(SPEED_UNIT);
    localparam logic [64:0] RECIP_FULL =
        ((65'd1 << RECIP_SHIFT) + 65'(SPEED_UNIT) - 65'd1) / 65'(SPEED_UNIT);
    localparam logic [PROD_W:0] RECIP = RECIP_FULL[PROD_W:0];
    localparam int RECIP_LO_W = 16;
    localparam int RECIP_HI_W = PROD_W + 1 - RECIP_LO_W;
    localparam logic [RECIP_LO_W-1:0] RECIP_LO = RECIP[RECIP_LO_W-1:0];
    localparam logic [RECIP_HI_W-1:0] RECIP_HI = RECIP[PROD_W:RECIP_LO_W];
    localparam int PP_LO_W = PROD_W + RECIP_LO_W;
    localparam int PP_HI_W = PROD_W + RECIP_HI_W;
    localparam int SUM_W   = PP_HI_W + RECIP_LO_W;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_PLAY  = 2'd2,
        FUNC_STOP  = 2'd3
    } t_func;

    typedef struct packed {
        logic [NOTE_W-1:0] freq;
        logic [NOTE_W-1:0] volume;
        logic [NOTE_W-1:0] duration;
    } t_note;

    typedef struct packed {
        logic capture;
        logic mem_write;
        logic mem_read;
        logic pos_play;
        logic pos_stop;
        logic mul_p;
        logic mul_lo;
        logic mul_hi;
        logic quot;
        logic load_result;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  note_due;
        logic  out_free;
    } t_dp_status;

endpackage

### rtl/timed_note_sequencer.sv
// Top level: a write note, play, stop or tick transfer is taken when the block is idle.
// Write, play and stop finish in decode; a tick that issues a note passes table read, three
// multiplies of the duration scaling and the quotient before the result state, and other ticks
// go there from decode. A result waits while the output stalls; the next transfer is taken in
// the cycle it appears. Synchronous active-low reset clears control, position and deadline,
// note_count to 0 and speed_scale to 500; the note table is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module timed_note_sequencer
    import tns_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_func,
    input  logic [TICK_W-1:0]    i_tick_ms,
    input  logic [ADDR_W-1:0]    i_note_index,
    input  logic [NOTE_W-1:0]    i_note_freq,
    input  logic [NOTE_W-1:0]    i_note_volume,
    input  logic [NOTE_W-1:0]    i_note_duration,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_tone_change,
    output logic [NOTE_W-1:0]    o_tone_freq,
    output logic [NOTE_W-1:0]    o_tone_volume,
    output logic                 o_playing
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    tns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    tns_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_tick_ms       (i_tick_ms),
        .i_note_index    (i_note_index),
        .i_note_freq     (i_note_freq),
        .i_note_volume   (i_note_volume),
        .i_note_duration (i_note_duration),
        .i_out_stall     (i_out_stall),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_out_valid     (o_out_valid),
        .o_tone_change   (o_tone_change),
        .o_tone_freq     (o_tone_freq),
        .o_tone_volume   (o_tone_volume),
        .o_playing       (o_playing)
    );

endmodule

### rtl/tns_datapath.sv
// Datapath of the note sequencer: configuration, note table, scaling arithmetic and result register.
`timescale 1ns / 1ps

module tns_datapath
    import tns_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [1:0]           i_func,
    input  logic [TICK_W-1:0]    i_tick_ms,
    input  logic [ADDR_W-1:0]    i_note_index,
    input  logic [NOTE_W-1:0]    i_note_freq,
    input  logic [NOTE_W-1:0]    i_note_volume,
    input  logic [NOTE_W-1:0]    i_note_duration,
    input  logic                 i_out_stall,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic                 o_out_valid,
    output logic                 o_tone_change,
    output logic [NOTE_W-1:0]    o_tone_freq,
    output logic [NOTE_W-1:0]    o_tone_volume,
    output logic                 o_playing
);

    t_note r_table [TABLE_DEPTH];

    logic [CNT_W-1:0]   r_note_count;
    logic [SPEED_W-1:0] r_speed_scale;
    logic [POS_W-1:0]   r_pos;
    logic [TICK_W-1:0]  r_deadline;

    t_func              r_func;
    logic [TICK_W-1:0]  r_tick;
    logic [ADDR_W-1:0]  r_idx;
    t_note              r_wr_note;
    t_note              r_rd_note;
    logic [PROD_W-1:0]  r_prod;
    logic [PP_LO_W-1:0] r_pp_lo;
    logic [PP_HI_W-1:0] r_pp_hi;
    logic [TICK_W-1:0]  r_quot;

    logic               r_out_valid;
    logic               r_tone_change;
    logic [NOTE_W-1:0]  r_tone_freq;
    logic [NOTE_W-1:0]  r_tone_volume;
    logic               r_playing;

    logic [POS_W-1:0]   w_count;
    logic               w_below;
    logic               w_late;
    logic               w_at_end;
    logic               w_wr_ok;
    logic [SUM_W-1:0]   n_sum;

    always_comb begin
        if (POS_W'(r_note_count) > POS_W'(TABLE_DEPTH)) begin
            w_count = POS_W'(TABLE_DEPTH);
        end else begin
            w_count = POS_W'(r_note_count);
        end
        w_below  = r_pos < w_count;
        w_late   = r_tick > r_deadline;
        w_at_end = r_pos == w_count;
        w_wr_ok  = POS_W'(r_idx) < POS_W'(TABLE_DEPTH);
        n_sum    = {r_pp_hi, RECIP_LO_W'(0)} + SUM_W'(r_pp_lo);
    end

    assign o_status.func     = r_func;
    assign o_status.note_due = w_below && w_late;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write && w_wr_ok) begin
            r_table[r_idx] <= r_wr_note;
        end
        if (i_cmd.mem_read) begin
            r_rd_note <= r_table[r_pos[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func    <= t_func'(i_func);
            r_tick    <= i_tick_ms;
            r_idx     <= i_note_index;
            r_wr_note <= '{freq: i_note_freq, volume: i_note_volume,
                           duration: i_note_duration};
        end
        if (i_cmd.mul_p) begin
            r_prod <= PROD_W'(r_rd_note.duration) * PROD_W'(r_speed_scale);
        end
        if (i_cmd.mul_lo) begin
            r_pp_lo <= PP_LO_W'(r_prod) * PP_LO_W'(RECIP_LO);
        end
        if (i_cmd.mul_hi) begin
            r_pp_hi <= PP_HI_W'(r_prod) * PP_HI_W'(RECIP_HI);
        end
        if (i_cmd.quot) begin
            r_quot <= TICK_W'(n_sum >> RECIP_SHIFT);
        end
        if (i_cmd.load_result) begin
            r_playing     <= w_below;
            r_tone_change <= (w_below || w_at_end) && w_late;
            r_tone_freq   <= (w_below && w_late) ? r_rd_note.freq : '0;
            r_tone_volume <= (w_below && w_late) ? r_rd_note.volume : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note_count  <= '0;
            r_speed_scale <= SPEED_RESET;
            r_pos         <= '0;
            r_deadline    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NOTE_COUNT:  r_note_count  <= i_cfg_data[CNT_W-1:0];
                    CFG_SPEED_SCALE: r_speed_scale <= i_cfg_data[SPEED_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.pos_play) begin
                r_pos <= '0;
            end else if (i_cmd.pos_stop) begin
                r_pos <= w_count;
            end else if (i_cmd.load_result && w_late) begin
                if (w_below) begin
                    r_pos      <= r_pos + POS_W'(1);
                    r_deadline <= r_tick + r_quot;
                end else if (w_at_end) begin
                    r_pos <= w_count + POS_W'(1);
                end
            end
            if (i_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tone_change = r_tone_change;
    assign o_tone_freq   = r_tone_freq;
    assign o_tone_volume = r_tone_volume;
    assign o_playing     = r_playing;

`ifndef NO_ASSERTIONS
    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_result |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over an untaken result");

    a_note_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_result && w_below && w_late) |=> (r_pos == $past(r_pos) + POS_W'(1)))
        else $error("issued note did not advance the position");

    a_silence_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_playing) |-> (r_tone_freq == '0 && r_tone_volume == '0))
        else $error("tone fields nonzero while not playing");

    a_pos_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.pos_play && !i_cmd.pos_stop && !i_cmd.load_result) |=> $stable(r_pos))
        else $error("position moved without a command");
`endif

endmodule

### rtl/tns_ctrl.sv
// Controller state machine that sequences each transfer through the datapath.
`timescale 1ns / 1ps

module tns_ctrl
    import tns_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_P,
        S_MUL_LO,
        S_MUL_HI,
        S_QUOT,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_status.func)
                    FUNC_WRITE: o_cmd.mem_write = 1'b1;
                    FUNC_PLAY:  o_cmd.pos_play  = 1'b1;
                    FUNC_STOP:  o_cmd.pos_stop  = 1'b1;
                    FUNC_TICK: begin
                        o_cmd.mem_read = 1'b1;
                        n_state = i_status.note_due ? S_MUL_P : S_RESULT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_MUL_P: begin
                o_cmd.mul_p = 1'b1;
                n_state     = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_QUOT;
            end
            S_QUOT: begin
                o_cmd.quot = 1'b1;
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

### tb/tb_timed_note_sequencer.sv
// Self-checking testbench for the note sequencer: predicts tone results and checks each tone result.
`timescale 1ns / 1ps

module tb_timed_note_sequencer;
    import tns_pkg::*;

    localparam int ITEMS_TOTAL  = 1850;
    localparam int QUIET_TAIL   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic              change;
        logic [NOTE_W-1:0] freq;
        logic [NOTE_W-1:0] volume;
        logic              playing;
    } t_tone;

    class tone_scoreboard;
        t_note               notes [TABLE_DEPTH];
        bit                  written [TABLE_DEPTH];
        logic [CNT_W-1:0]    note_count;
        logic [SPEED_W-1:0]  speed_scale;
        int unsigned         position;
        logic [TICK_W-1:0]   deadline;
        t_tone               tone_q [$];
        int                  errors;
        int                  ticks;
        int                  notes_issued;
        int                  silences;

        function new();
            note_count = '0;
            speed_scale = SPEED_RESET;
            position = 0;
            deadline = '0;
            errors = 0;
            ticks = 0;
            notes_issued = 0;
            silences = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            if (index == CFG_NOTE_COUNT) begin
                note_count = data[CNT_W-1:0];
            end else begin
                speed_scale = data[SPEED_W-1:0];
            end
        endfunction

        function int unsigned pending();
            return tone_q.size();
        endfunction

        function void note_transfer(t_func func, logic [TICK_W-1:0] tick,
                                    logic [ADDR_W-1:0] index, logic [NOTE_W-1:0] freq,
                                    logic [NOTE_W-1:0] volume, logic [NOTE_W-1:0] duration);
            t_tone           res;
            int unsigned     count;
            longint unsigned span;
            count = (note_count > TABLE_DEPTH) ? TABLE_DEPTH : note_count;
            res = '0;
            case (func)
                FUNC_WRITE: begin
                    notes[index] = '{freq: freq, volume: volume, duration: duration};
                    written[index] = 1'b1;
                end
                FUNC_PLAY: begin
                    position = 0;
                end
                FUNC_STOP: begin
                    position = count;
                end
                default: begin
                    if (position < count) begin
                        res.playing = 1'b1;
                        if (tick > deadline) begin
                            span = notes[position].duration;
                            span = span * speed_scale / SPEED_UNIT;
                            res.change = 1'b1;
                            res.freq = notes[position].freq;
                            res.volume = notes[position].volume;
                            deadline = tick + span[TICK_W-1:0];
                            position = position + 1;
                            notes_issued++;
                        end
                    end else if (position == count && tick > deadline) begin
                        res.change = 1'b1;
                        position = count + 1;
                        silences++;
                    end
                    tone_q.push_back(res);
                    ticks++;
                end
            endcase
        endfunction

        function void check_tone(logic change, logic [NOTE_W-1:0] freq,
                                 logic [NOTE_W-1:0] volume, logic playing);
            t_tone exp_tone;
            if (tone_q.size() == 0) begin
                $error("Tone result arrived with no tick outstanding");
                errors++;
                return;
            end
            exp_tone = tone_q.pop_front();
            if (change !== exp_tone.change) begin
                $error("tone_change: expected %0d, actual %0d", exp_tone.change, change);
                errors++;
            end
            if (freq !== exp_tone.freq) begin
                $error("tone_freq: expected %0d, actual %0d", exp_tone.freq, freq);
                errors++;
            end
            if (volume !== exp_tone.volume) begin
                $error("tone_volume: expected %0d, actual %0d", exp_tone.volume, volume);
                errors++;
            end
            if (playing !== exp_tone.playing) begin
                $error("playing: expected %0d, actual %0d", exp_tone.playing, playing);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_func = '0;
    logic [TICK_W-1:0]    i_tick_ms = '0;
    logic [ADDR_W-1:0]    i_note_index = '0;
    logic [NOTE_W-1:0]    i_note_freq = '0;
    logic [NOTE_W-1:0]    i_note_volume = '0;
    logic [NOTE_W-1:0]    i_note_duration = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_tone_change;
    logic [NOTE_W-1:0]    o_tone_freq;
    logic [NOTE_W-1:0]    o_tone_volume;
    logic                 o_playing;

    tone_scoreboard sb;
    bit             in_idle_on;
    bit             out_idle_on;
    int             stall_left;
    int             quiet_cycles;
    int             items_sent;
    int             settings;

    timed_note_sequencer dut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_tone(o_tone_change, o_tone_freq, o_tone_volume, o_playing);
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(0, 3);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $error("No transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [NOTE_W-1:0] rand_duration();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return NOTE_W'($urandom);
        return NOTE_W'($urandom_range(1, 400));
    endfunction

    task automatic send_item(t_func func, logic [TICK_W-1:0] tick, logic [ADDR_W-1:0] index,
                             logic [NOTE_W-1:0] freq, logic [NOTE_W-1:0] volume,
                             logic [NOTE_W-1:0] duration);
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= func;
        i_tick_ms <= tick;
        i_note_index <= index;
        i_note_freq <= freq;
        i_note_volume <= volume;
        i_note_duration <= duration;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_transfer(func, tick, index, freq, volume, duration);
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(logic [CFG_W-1:0] count_word, logic [CFG_W-1:0] speed_word);
        int used;
        drain();
        used = (count_word[CNT_W-1:0] > TABLE_DEPTH) ? TABLE_DEPTH
                                                     : int'(count_word[CNT_W-1:0]);
        for (int i = 0; i < used; i++) begin
            if (!sb.written[i]) begin
                send_item(FUNC_WRITE, $urandom, ADDR_W'(i), NOTE_W'($urandom),
                          NOTE_W'($urandom), rand_duration());
            end
        end
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_NOTE_COUNT;
        i_cfg_data <= count_word;
        @(posedge i_clk);
        sb.set_reg(CFG_NOTE_COUNT, count_word);
        i_cfg_index <= CFG_SPEED_SCALE;
        i_cfg_data <= speed_word;
        @(posedge i_clk);
        sb.set_reg(CFG_SPEED_SCALE, speed_word);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    initial begin
        logic [TICK_W-1:0] now_ms;
        logic [CFG_W-1:0]  count_word;
        logic [CFG_W-1:0]  speed_word;
        int                phase_len;
        int                r;
        t_func             func;

        sb = new();
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With no notes in use, the first late tick gives silence and then the block rests.
        send_item(FUNC_TICK, 32'd0, '0, '0, '0, '0);
        send_item(FUNC_TICK, 32'd1, '0, '0, '0, '0);
        send_item(FUNC_TICK, 32'hFFFF_FFFF, '0, '0, '0, '0);
        send_item(FUNC_WRITE, '0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(FUNC_WRITE, '0, 8'd1, 16'h0000, 16'h0000, 16'h0000);
        send_item(FUNC_WRITE, '0, 8'd2, 16'h5A5A, 16'hA5A5, 16'd1000);
        send_item(FUNC_WRITE, '0, 8'd255, 16'h1234, 16'h8765, 16'd7);
        configure(CFG_W'(3), SPEED_RESET);
        send_item(FUNC_PLAY, '0, '0, '0, '0, '0);
        send_item(FUNC_TICK, 32'd10, '0, '0, '0, '0);
        send_item(FUNC_TICK, 32'd65545, '0, '0, '0, '0);
        send_item(FUNC_TICK, 32'd65546, '0, '0, '0, '0);
        send_item(FUNC_TICK, 32'd65546, '0, '0, '0, '0);
        send_item(FUNC_TICK, 32'd65547, '0, '0, '0, '0);
        send_item(FUNC_TICK, 32'd66548, '0, '0, '0, '0);
        send_item(FUNC_TICK, 32'd70000, '0, '0, '0, '0);
        send_item(FUNC_STOP, '0, '0, '0, '0, '0);
        send_item(FUNC_TICK, 32'd80000, '0, '0, '0, '0);
        send_item(FUNC_PLAY, '0, '0, '0, '0, '0);
        send_item(FUNC_TICK, 32'hFFFF_FF00, '0, '0, '0, '0);
        send_item(FUNC_TICK, 32'hFFFF_FFFF, '0, '0, '0, '0);
        // Lowering the count below the position leaves the block idle until play or stop.
        configure({7'h7F, 9'd1}, 16'hFFFF);
        send_item(FUNC_TICK, 32'd0, '0, '0, '0, '0);
        send_item(FUNC_STOP, '0, '0, '0, '0, '0);
        send_item(FUNC_TICK, 32'd5, '0, '0, '0, '0);
        send_item(FUNC_PLAY, '0, '0, '0, '0, '0);
        send_item(FUNC_TICK, 32'd100, '0, '0, '0, '0);

        now_ms = 32'd200;
        while (items_sent < ITEMS_TOTAL) begin
            in_idle_on = (items_sent < ITEMS_TOTAL - QUIET_TAIL) && $urandom_range(0, 3) != 0;
            out_idle_on = (items_sent < ITEMS_TOTAL - QUIET_TAIL) && $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 9))
                0: r = 0;
                1: r = 1;
                2: r = TABLE_DEPTH;
                3: r = $urandom_range(TABLE_DEPTH + 1, 511);
                default: r = $urandom_range(2, 12);
            endcase
            count_word = {7'($urandom), CNT_W'(r)};
            case ($urandom_range(0, 5))
                0: speed_word = '0;
                1: speed_word = SPEED_RESET;
                2: speed_word = 16'hFFFF;
                3: speed_word = CFG_W'($urandom);
                default: speed_word = CFG_W'($urandom_range(100, 1000));
            endcase
            configure(count_word, speed_word);
            if ($urandom_range(0, 9) < 7) begin
                send_item(FUNC_PLAY, $urandom, ADDR_W'($urandom), NOTE_W'($urandom),
                          NOTE_W'($urandom), NOTE_W'($urandom));
            end
            phase_len = $urandom_range(20, 70);
            repeat (phase_len) begin
                r = $urandom_range(0, 99);
                if (r < 68) begin
                    r = $urandom_range(0, 99);
                    if (r < 45) begin
                        now_ms = now_ms + $urandom_range(0, 60);
                    end else if (r < 85) begin
                        now_ms = sb.deadline + $urandom_range(0, 2);
                    end else if (r < 93) begin
                        now_ms = $urandom;
                    end else begin
                        now_ms = 32'hFFFF_FFFF - $urandom_range(0, 100);
                    end
                    send_item(FUNC_TICK, now_ms, ADDR_W'($urandom), NOTE_W'($urandom),
                              NOTE_W'($urandom), NOTE_W'($urandom));
                end else begin
                    if (r < 82) begin
                        func = FUNC_WRITE;
                    end else if (r < 92) begin
                        func = FUNC_PLAY;
                    end else begin
                        func = FUNC_STOP;
                    end
                    send_item(func, $urandom, ADDR_W'($urandom), NOTE_W'($urandom),
                              NOTE_W'($urandom), rand_duration());
                end
            end
        end

        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        drain();
        $display("Covered %0d transfers over %0d register settings:",
                 items_sent, settings);
        $display("%0d ticks, %0d notes issued, %0d silences.",
                 sb.ticks, sb.notes_issued, sb.silences);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
